/* sv/epm_pkg.sv */
// shared types for the pose-to-transform block
// payload structs for both channels and the front-to-back queue entry
`default_nettype none

package epm_pkg;

    // one pose at the input
    typedef struct packed {
        logic               mode;
        logic               is_3d;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] angle_a;
        logic signed [31:0] angle_b;
        logic signed [31:0] angle_g;
    } pose_t;

    // one matrix row at the output
    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] elem_c0;
        logic signed [31:0] elem_c1;
        logic signed [31:0] elem_c2;
        logic signed [35:0] trans_c3;
        logic               last_row;
    } row_t;

    // pose data that rides along with the angles
    typedef struct packed {
        logic               mode;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } meta_t;

    // classified pose: folded Q2.30 angles and negate flags
    typedef struct packed {
        meta_t              meta;
        logic signed [33:0] za;
        logic signed [33:0] zb;
        logic signed [33:0] zg;
        logic               na;
        logic               nb;
        logic               ng;
    } qentry_t;

    localparam int QDEPTH = 2;

endpackage

`default_nettype wire

/* sv/epm_front.sv */
// front end: wraps the three angles (only alpha for planar poses), folds them into the cordic range
// depends on epm_pkg
`default_nettype none

module epm_front
    import epm_pkg::*;
(
    input  wire pose_t   pose,
    output qentry_t      entry
);

    localparam logic signed [32:0] PI_Q28     = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28 = 33'sd1686629713;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;

    // wrap into [-pi, pi); one step covers the whole Q3.28 range
    function automatic logic signed [32:0] wrap(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        if (w >= PI_Q28)
            w = w - TWO_PI_Q28;
        else if (w < -PI_Q28)
            w = w + TWO_PI_Q28;
        return w;
    endfunction

    // scale to Q2.30 and move by pi towards zero when beyond a quarter turn
    function automatic logic [34:0] fold(input logic signed [32:0] w);
        logic signed [34:0] z;
        logic               n;
        z = {w, 2'b00};
        n = 1'b0;
        if (z > HALF_PI_Q30)
        begin
            z = z - PI_Q30;
            n = 1'b1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z = z + PI_Q30;
            n = 1'b1;
        end
        return {n, z[33:0]};
    endfunction

    logic [34:0] fa, fb, fg;

    // planar poses force z, beta and gamma to zero
    always_comb
    begin
        fa = fold(wrap(pose.angle_a));
        fb = pose.is_3d ? fold(wrap(pose.angle_b)) : '0;
        fg = pose.is_3d ? fold(wrap(pose.angle_g)) : '0;
        entry.meta.mode = pose.mode;
        entry.meta.px   = pose.pos_x;
        entry.meta.py   = pose.pos_y;
        entry.meta.pz   = pose.is_3d ? pose.pos_z : '0;
        entry.za = fa[33:0];
        entry.zb = fb[33:0];
        entry.zg = fg[33:0];
        entry.na = fa[34];
        entry.nb = fb[34];
        entry.ng = fg[34];
    end

endmodule

`default_nettype wire

/* sv/epm_queue.sv */
// short queue between the front end and the back end
// depends on epm_pkg
`default_nettype none

module epm_queue
    import epm_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          push,
    input  wire qentry_t wdata,
    input  wire          pop,
    output qentry_t      rdata,
    output logic         full,
    output logic         empty
);

    localparam int AW = $clog2(QDEPTH);

    qentry_t        mem [0:QDEPTH-1];
    logic [AW-1:0]  wptr_reg, wptr_next;
    logic [AW-1:0]  rptr_reg, rptr_next;
    logic [AW:0]    cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = (cnt_reg == (AW+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rptr_reg];

    // pointer and count update
    always_comb
    begin
        wptr_next = do_push ? ((wptr_reg == AW'(QDEPTH-1)) ? '0 : wptr_reg + 1'b1) : wptr_reg;
        rptr_next = do_pop ? ((rptr_reg == AW'(QDEPTH-1)) ? '0 : rptr_reg + 1'b1) : rptr_reg;
        cnt_next  = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* sv/epm_back.sv */
// back end: pipelined cordic, matrix products, row serializer
// depends on epm_pkg
`default_nettype none

module epm_back
    import epm_pkg::*;
#(
    parameter int STEPS = 24
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire qentry_t head,
    input  wire          head_valid,
    output logic         pop,
    output logic         row_valid,
    input  wire          row_ready,
    output row_t         row
);

    localparam logic signed [33:0] GAIN   = 34'sd652032874;
    localparam logic signed [33:0] ONE_P  = 34'sd1073741824;
    localparam logic signed [33:0] ONE_N  = -34'sd1073741824;

    // rounded arctangent of 2^-i in Q2.30
    function automatic logic signed [33:0] atan_q30(input int i);
        case (i)
            0:       return 34'sd843314857;
            1:       return 34'sd497837829;
            2:       return 34'sd263043837;
            3:       return 34'sd133525159;
            4:       return 34'sd67021687;
            5:       return 34'sd33543516;
            6:       return 34'sd16775851;
            7:       return 34'sd8388437;
            8:       return 34'sd4194283;
            9:       return 34'sd2097149;
            default: return (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
    endfunction

    // product rounded half up, shifted back by 30
    function automatic logic signed [33:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[63:30];
    endfunction

    function automatic logic signed [31:0] ent(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [35:0] sat36(input logic signed [37:0] v);
        if (v > 38'sd34359738367)
            return 36'sh7ffffffff;
        else if (v < -38'sd34359738368)
            return 36'sh800000000;
        return v[35:0];
    endfunction

    function automatic logic signed [31:0] sc_out(input logic signed [33:0] v,
                                                  input logic n);
        logic signed [33:0] c;
        c = (v > ONE_P) ? ONE_P : ((v < ONE_N) ? ONE_N : v);
        c = n ? -c : c;
        return c[31:0];
    endfunction

    logic adv;

    // cordic stage registers: index k holds the state after k steps
    logic               cv_reg [0:STEPS];
    logic signed [33:0] cx_reg [0:STEPS][0:2];
    logic signed [33:0] cy_reg [0:STEPS][0:2];
    logic signed [33:0] cz_reg [0:STEPS][0:2];
    logic               cn_reg [0:STEPS][0:2];
    meta_t              cm_reg [0:STEPS];

    assign pop = adv && head_valid;

    // stage 0 loads from the queue head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (adv)
            cv_reg[0] <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cm_reg[0] <= head.meta;
            cz_reg[0][0] <= head.za;
            cz_reg[0][1] <= head.zb;
            cz_reg[0][2] <= head.zg;
            cn_reg[0][0] <= head.na;
            cn_reg[0][1] <= head.nb;
            cn_reg[0][2] <= head.ng;
            for (int l = 0; l < 3; l++)
            begin
                cx_reg[0][l] <= GAIN;
                cy_reg[0][l] <= '0;
            end
        end
    end

    // one shift-add rotation per stage, three angle lanes side by side
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[k+1] <= 1'b0;
            else if (adv)
                cv_reg[k+1] <= cv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cm_reg[k+1] <= cm_reg[k];
                for (int l = 0; l < 3; l++)
                begin
                    cn_reg[k+1][l] <= cn_reg[k][l];
                    if (cz_reg[k][l] >= 0)
                    begin
                        cx_reg[k+1][l] <= cx_reg[k][l] - (cy_reg[k][l] >>> k);
                        cy_reg[k+1][l] <= cy_reg[k][l] + (cx_reg[k][l] >>> k);
                        cz_reg[k+1][l] <= cz_reg[k][l] - atan_q30(k);
                    end
                    else
                    begin
                        cx_reg[k+1][l] <= cx_reg[k][l] + (cy_reg[k][l] >>> k);
                        cy_reg[k+1][l] <= cy_reg[k][l] - (cx_reg[k][l] >>> k);
                        cz_reg[k+1][l] <= cz_reg[k][l] + atan_q30(k);
                    end
                end
            end
        end
    end

    // later stages: clamped sin/cos, products, entries, translation products
    logic               sv_reg, p1v_reg, p2v_reg, p3v_reg, p4v_reg;
    meta_t              sm_reg, p1m_reg, p2m_reg, p3m_reg, p4m_reg;
    logic signed [31:0] sa_reg, ca_reg, sb_reg, cb_reg, sg_reg, cg_reg;
    logic signed [31:0] cacb_reg, casb_reg, cgsa_reg, sasg_reg, cacg_reg;
    logic signed [31:0] cbsa_reg, sasb_reg, cbsg_reg, cbcg_reg, casg_reg;
    logic signed [31:0] p1sb_reg, p1sg_reg;
    logic signed [33:0] q01_reg, q02_reg, q11_reg, q12_reg;
    logic signed [31:0] p2sasg_reg, p2cgsa_reg, p2cacg_reg, p2casg_reg;
    logic signed [31:0] p2cacb_reg, p2cbsa_reg, p2sb_reg, p2cbsg_reg, p2cbcg_reg;
    logic signed [31:0] r_reg [0:2][0:2];
    logic signed [31:0] r4_reg [0:2][0:2];
    logic signed [33:0] t_reg [0:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg  <= 1'b0;
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
            p3v_reg <= 1'b0;
            p4v_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg  <= cv_reg[STEPS];
            p1v_reg <= sv_reg;
            p2v_reg <= p1v_reg;
            p3v_reg <= p2v_reg;
            p4v_reg <= p3v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // clamp and undo the fold
            sm_reg <= cm_reg[STEPS];
            sa_reg <= sc_out(cy_reg[STEPS][0], cn_reg[STEPS][0]);
            ca_reg <= sc_out(cx_reg[STEPS][0], cn_reg[STEPS][0]);
            sb_reg <= sc_out(cy_reg[STEPS][1], cn_reg[STEPS][1]);
            cb_reg <= sc_out(cx_reg[STEPS][1], cn_reg[STEPS][1]);
            sg_reg <= sc_out(cy_reg[STEPS][2], cn_reg[STEPS][2]);
            cg_reg <= sc_out(cx_reg[STEPS][2], cn_reg[STEPS][2]);

            // pair products
            p1m_reg  <= sm_reg;
            cacb_reg <= 32'(mul30(ca_reg, cb_reg));
            casb_reg <= 32'(mul30(ca_reg, sb_reg));
            cgsa_reg <= 32'(mul30(cg_reg, sa_reg));
            sasg_reg <= 32'(mul30(sa_reg, sg_reg));
            cacg_reg <= 32'(mul30(ca_reg, cg_reg));
            cbsa_reg <= 32'(mul30(cb_reg, sa_reg));
            sasb_reg <= 32'(mul30(sa_reg, sb_reg));
            cbsg_reg <= 32'(mul30(cb_reg, sg_reg));
            cbcg_reg <= 32'(mul30(cb_reg, cg_reg));
            casg_reg <= 32'(mul30(ca_reg, sg_reg));
            p1sb_reg <= sb_reg;
            p1sg_reg <= sg_reg;

            // triple products
            p2m_reg    <= p1m_reg;
            q01_reg    <= mul30(casb_reg, p1sg_reg);
            q02_reg    <= mul30(cacg_reg, p1sb_reg);
            q11_reg    <= mul30(sasb_reg, p1sg_reg);
            q12_reg    <= mul30(cgsa_reg, p1sb_reg);
            p2sasg_reg <= sasg_reg;
            p2cgsa_reg <= cgsa_reg;
            p2cacg_reg <= cacg_reg;
            p2casg_reg <= casg_reg;
            p2cacb_reg <= cacb_reg;
            p2cbsa_reg <= cbsa_reg;
            p2sb_reg   <= p1sb_reg;
            p2cbsg_reg <= cbsg_reg;
            p2cbcg_reg <= cbcg_reg;

            // rotation entries, the sums saturated
            p3m_reg     <= p2m_reg;
            r_reg[0][0] <= p2cacb_reg;
            r_reg[0][1] <= ent(q01_reg - 34'(p2cgsa_reg));
            r_reg[0][2] <= ent(34'(p2sasg_reg) + q02_reg);
            r_reg[1][0] <= p2cbsa_reg;
            r_reg[1][1] <= ent(34'(p2cacg_reg) + q11_reg);
            r_reg[1][2] <= ent(q12_reg - 34'(p2casg_reg));
            r_reg[2][0] <= ent(-34'(p2sb_reg));
            r_reg[2][1] <= p2cbsg_reg;
            r_reg[2][2] <= p2cbcg_reg;

            // translation products
            p4m_reg  <= p3m_reg;
            r4_reg   <= r_reg;
            t_reg[0] <= mul30(p3m_reg.px, r_reg[0][0]);
            t_reg[1] <= mul30(p3m_reg.py, r_reg[0][1]);
            t_reg[2] <= mul30(p3m_reg.py, r_reg[1][1]);
            t_reg[3] <= mul30(p3m_reg.px, r_reg[1][0]);
            t_reg[4] <= mul30(p3m_reg.px, r_reg[2][0]);
            t_reg[5] <= mul30(p3m_reg.py, r_reg[2][1]);
            t_reg[6] <= mul30(p3m_reg.pz, r_reg[2][0]);
            t_reg[7] <= mul30(p3m_reg.pz, r_reg[2][1]);
            t_reg[8] <= mul30(p3m_reg.pz, r_reg[2][2]);
        end
    end

    // row serializer holding one finished matrix
    row_t       rows_reg [0:2];
    row_t       rows_next [0:2];
    logic       ser_valid_reg, ser_valid_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       load;
    logic signed [37:0] tr [0:2];

    assign load      = p4v_reg && (!ser_valid_reg || (row_ready && cnt_reg == 2'd2));
    assign adv       = !p4v_reg || load;
    assign row_valid = ser_valid_reg;
    assign row       = rows_reg[cnt_reg];

    // translation column sums and row assembly
    always_comb
    begin
        if (!p4m_reg.mode)
        begin
            tr[0] = 38'(t_reg[0]) + 38'(t_reg[1]);
            tr[1] = 38'(t_reg[2]) + 38'(t_reg[3]);
            tr[2] = 38'(p4m_reg.pz) + 38'(t_reg[4]) + 38'(t_reg[5]);
        end
        else
        begin
            tr[0] = -38'(t_reg[6]) - 38'(p4m_reg.px);
            tr[1] = -38'(p4m_reg.py) - 38'(t_reg[7]);
            tr[2] = -38'(t_reg[8]);
        end
        for (int k = 0; k < 3; k++)
        begin
            rows_next[k].row_index = 2'(k);
            rows_next[k].elem_c0   = p4m_reg.mode ? r4_reg[0][k] : r4_reg[k][0];
            rows_next[k].elem_c1   = p4m_reg.mode ? r4_reg[1][k] : r4_reg[k][1];
            rows_next[k].elem_c2   = p4m_reg.mode ? r4_reg[2][k] : r4_reg[k][2];
            rows_next[k].trans_c3  = sat36(tr[k]);
            rows_next[k].last_row  = (k == 2);
        end
    end

    // serializer control
    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        cnt_next       = cnt_reg;
        if (load)
        begin
            ser_valid_next = 1'b1;
            cnt_next       = 2'd0;
        end
        else if (ser_valid_reg && row_ready)
        begin
            if (cnt_reg == 2'd2)
                ser_valid_next = 1'b0;
            else
                cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rows_reg <= rows_next;
    end

endmodule

`default_nettype wire

/* sv/euler_pose_to_transform_matrix.sv */
// top level: pose in, three transform rows out
// depends on epm_pkg, epm_front, epm_queue, epm_back
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------
//   pose    | pose_valid, pose_ready | pose_t, one pose per transfer
//   row     | row_valid, row_ready   | row_t, three rows per pose
//
// the row serializer sends the three rows of a matrix one per cycle while
// row_ready is high, and loads the next matrix as the last row is taken.
// reset clears valid bits, queue pointers and the serializer; no clearing pass.
// a stalled row channel holds the back pipeline; the 2-entry queue keeps
// taking poses until it fills.
`default_nettype none

module euler_pose_to_transform_matrix
    import epm_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        pose_valid,
    output logic       pose_ready,
    input  wire pose_t pose,
    output logic       row_valid,
    input  wire        row_ready,
    output row_t       row
);

    qentry_t entry, head;
    logic    full, empty, pop;

    assign pose_ready = !full;

    epm_front u_front (
        .pose  (pose),
        .entry (entry)
    );

    epm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (pose_valid),
        .wdata (entry),
        .pop   (pop),
        .rdata (head),
        .full  (full),
        .empty (empty)
    );

    epm_back #(
        .STEPS (CORDIC_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!empty),
        .pop        (pop),
        .row_valid  (row_valid),
        .row_ready  (row_ready),
        .row        (row)
    );

endmodule

`default_nettype wire

/* sv/epm_checker.sv */
// port-level checks for the pose-to-transform block
// depends on epm_pkg; bound to euler_pose_to_transform_matrix
`default_nettype none

module epm_checker
    import epm_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        row_valid,
    input wire        row_ready,
    input wire row_t  row
);

    // a stalled row holds
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_ready |=> row_valid && $stable(row))
        else $error("row changed while stalled");

    // last mark only on the third row
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (row.last_row == (row.row_index == 2'd2)))
        else $error("last_row does not match row_index");

    // a row other than the last, once taken, is followed at once by the next row
    a_row0_next: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && row.row_index == 2'd0
        |=> row_valid && row.row_index == 2'd1)
        else $error("row 1 did not follow row 0");

    a_row1_next: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && row.row_index == 2'd1
        |=> row_valid && row.row_index == 2'd2)
        else $error("row 2 did not follow row 1");

endmodule

bind euler_pose_to_transform_matrix epm_checker u_epm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row)
);

`default_nettype wire
